// ===== src/crc8fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fc_pkg
// shared types, register codes and crc helpers for the crc-8 frame block
// ----------------------------------------------------------------------------
package crc8fc_pkg;

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_POLYNOMIAL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RX_FRAME_LENGTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TX_FRAME_LENGTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_ENABLE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_BYTE        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_CHECK_ENABLE = 3'd5;
   localparam int CSR_DATA_W = 9;

   // register reset values
   localparam logic [7:0] CRC_POLYNOMIAL_RESET   = 8'h6F;
   localparam logic [8:0] RX_FRAME_LENGTH_RESET  = 9'd3;
   localparam logic [8:0] TX_FRAME_LENGTH_RESET  = 9'd16;
   localparam logic       SYNC_ENABLE_RESET      = 1'b0;
   localparam logic [7:0] SYNC_BYTE_RESET        = 8'h0B;
   localparam logic       CRC_CHECK_ENABLE_RESET = 1'b1;

   // frame length limits
   localparam logic [8:0] MIN_FRAME_LEN = 9'd2;
   localparam logic [8:0] MAX_FRAME_LEN = 9'd256;

   localparam logic [7:0] CRC_INIT = 8'h00;
   localparam logic [7:0] CRC_TOP_BIT = 8'h80;

   // input and result codes
   localparam logic ACTION_RX = 1'b0;
   localparam logic ACTION_TX = 1'b1;
   localparam logic KIND_TX_BYTE = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] crc_polynomial;
      logic [8:0] rx_frame_length;
      logic [8:0] tx_frame_length;
      logic       sync_enable;
      logic [7:0] sync_byte;
      logic       crc_check_enable;
   } cfg_type;

   // one queue entry: one result, or a tx byte followed by its frame crc
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] crc_value;
      logic       good;
      logic       pair;
   } entry_type;

   // msb-first crc-8 over one byte
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
                                              input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP_BIT) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // position of the last byte of a frame, length clamped to the legal range
   function automatic logic [7:0] final_position(input logic [8:0] len);
      logic [8:0] l;
      l = len;
      if (len < MIN_FRAME_LEN) begin
         l = MIN_FRAME_LEN;
      end else if (len > MAX_FRAME_LEN) begin
         l = MAX_FRAME_LEN;
      end
      return 8'(l - 9'd1);
   endfunction

endpackage

// ===== src/crc8fc_front.sv =====
// ----------------------------------------------------------------------------
// crc8fc_front
// takes request bytes, tracks frame position and running crc, queues results
// ----------------------------------------------------------------------------
module crc8fc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  crc8fc_pkg::cfg_type   cfg,
   input  logic                  req_push,
   input  logic                  req_action,
   input  logic [7:0]            req_data_byte,
   input  logic                  queue_full,
   output logic                  accept,
   output logic                  queue_push,
   output crc8fc_pkg::entry_type queue_entry
);

   logic [7:0] rx_position_ff, rx_position_in;
   logic [7:0] rx_crc_ff, rx_crc_in;
   logic [7:0] tx_position_ff, tx_position_in;
   logic [7:0] tx_crc_ff, tx_crc_in;

   logic [7:0] rx_final;
   logic [7:0] tx_final;
   logic [7:0] rx_crc_next;
   logic [7:0] tx_crc_next;
   logic [8:0] tx_count;
   logic       sync_drop;

   assign accept = req_push && !queue_full;

   always_comb begin
      rx_final    = crc8fc_pkg::final_position(cfg.rx_frame_length);
      tx_final    = crc8fc_pkg::final_position(cfg.tx_frame_length);
      rx_crc_next = crc8fc_pkg::crc8_update(rx_crc_ff, req_data_byte, cfg.crc_polynomial);
      tx_crc_next = crc8fc_pkg::crc8_update(tx_crc_ff, req_data_byte, cfg.crc_polynomial);
      tx_count    = {1'b0, tx_position_ff} + 9'd1;
      sync_drop   = (rx_position_ff == 8'd0) && cfg.sync_enable &&
                    (req_data_byte != cfg.sync_byte);

      rx_position_in = rx_position_ff;
      rx_crc_in      = rx_crc_ff;
      tx_position_in = tx_position_ff;
      tx_crc_in      = tx_crc_ff;
      queue_push     = 1'b0;

      queue_entry.kind      = crc8fc_pkg::KIND_TX_BYTE;
      queue_entry.data      = req_data_byte;
      queue_entry.crc_value = tx_crc_next;
      queue_entry.good      = 1'b0;
      queue_entry.pair      = 1'b0;

      if (accept) begin
         if (req_action == crc8fc_pkg::ACTION_RX) begin
            if (sync_drop) begin
               // frame start byte not the sync byte: dropped
            end else if (rx_position_ff < rx_final) begin
               rx_crc_in      = rx_crc_next;
               rx_position_in = rx_position_ff + 8'd1;
            end else begin
               queue_push       = 1'b1;
               queue_entry.kind = crc8fc_pkg::KIND_VERDICT;
               queue_entry.data = rx_crc_ff;
               queue_entry.good = cfg.crc_check_enable ? (req_data_byte == rx_crc_ff) : 1'b1;
               rx_position_in   = 8'd0;
               rx_crc_in        = crc8fc_pkg::CRC_INIT;
            end
         end else begin
            queue_push = 1'b1;
            if (tx_count < {1'b0, tx_final}) begin
               tx_crc_in      = tx_crc_next;
               tx_position_in = tx_count[7:0];
            end else begin
               queue_entry.pair = 1'b1;
               tx_crc_in        = crc8fc_pkg::CRC_INIT;
               tx_position_in   = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_position_ff <= 8'd0;
         rx_crc_ff      <= crc8fc_pkg::CRC_INIT;
         tx_position_ff <= 8'd0;
         tx_crc_ff      <= crc8fc_pkg::CRC_INIT;
      end else begin
         rx_position_ff <= rx_position_in;
         rx_crc_ff      <= rx_crc_in;
         tx_position_ff <= tx_position_in;
         tx_crc_ff      <= tx_crc_in;
      end
   end

endmodule

// ===== src/crc8fc_queue.sv =====
// ----------------------------------------------------------------------------
// crc8fc_queue
// short first-in first-out queue of result entries between front and back
// ----------------------------------------------------------------------------
module crc8fc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  crc8fc_pkg::entry_type push_entry,
   input  logic                  pop,
   output crc8fc_pkg::entry_type head,
   output logic                  full,
   output logic                  empty
);

   crc8fc_pkg::entry_type entry_ff [crc8fc_pkg::QUEUE_DEPTH];

   logic [crc8fc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crc8fc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crc8fc_pkg::QUEUE_CW-1:0] count_ff, count_in;

   localparam logic [crc8fc_pkg::QUEUE_AW-1:0] LAST_SLOT =
      crc8fc_pkg::QUEUE_AW'(crc8fc_pkg::QUEUE_DEPTH - 1);
   localparam logic [crc8fc_pkg::QUEUE_CW-1:0] FULL_COUNT =
      crc8fc_pkg::QUEUE_CW'(crc8fc_pkg::QUEUE_DEPTH);

   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/crc8fc_back.sv =====
// ----------------------------------------------------------------------------
// crc8fc_back
// output register: turns queue entries into one or two response transfers
// ----------------------------------------------------------------------------
module crc8fc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  crc8fc_pkg::entry_type head,
   input  logic                  queue_empty,
   output logic                  queue_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_crc_byte,
   output logic                  rsp_crc_good,
   output logic                  rsp_last
);

   logic                  valid_ff, valid_in;
   logic                  phase_ff, phase_in;
   crc8fc_pkg::entry_type entry_ff, entry_in;

   logic taken;
   logic second;

   always_comb begin
      taken     = valid_ff && rsp_pop;
      second    = entry_ff.pair && !phase_ff;
      queue_pop = !queue_empty && (!valid_ff || (taken && !second));

      valid_in = valid_ff;
      phase_in = phase_ff;
      entry_in = entry_ff;
      if (taken && second) begin
         phase_in = 1'b1;
      end else if (queue_pop) begin
         valid_in = 1'b1;
         phase_in = 1'b0;
         entry_in = head;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // second transfer of a pair is the appended crc byte
   always_comb begin
      rsp_empty = !valid_ff;
      if (phase_ff) begin
         rsp_kind        = crc8fc_pkg::KIND_TX_BYTE;
         rsp_out_byte    = entry_ff.crc_value;
         rsp_is_crc_byte = 1'b1;
         rsp_crc_good    = 1'b0;
         rsp_last        = 1'b1;
      end else begin
         rsp_kind        = entry_ff.kind;
         rsp_out_byte    = entry_ff.data;
         rsp_is_crc_byte = 1'b0;
         rsp_crc_good    = entry_ff.good;
         rsp_last        = !entry_ff.pair;
      end
   end

endmodule

// ===== src/crc8_frame_check_and_append.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_check_and_append
// crc-8 frame check on receive and crc append on transmit
// ----------------------------------------------------------------------------
// a result passes through the queue, then the output register, before it shows on the rsp ports
// throughput: one request per cycle while req_full is low; one response transfer a cycle
//   while rsp_pop is high, so a frame-end tx byte holds the output register for its crc too
// the 4-entry queue between front and back absorbs that extra transfer and rsp stalls
// reset: synchronous, active high; clears frame state, queue and output register,
//   and loads the csr defaults (polynomial 0x6f, rx length 3, tx length 16)
module crc8_frame_check_and_append (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_action,
   input  logic [7:0]                            req_data_byte,
   // response side
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_kind,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_is_crc_byte,
   output logic                                  rsp_crc_good,
   output logic                                  rsp_last,
   // register writes
   input  logic                                  csr_write_enable,
   input  logic [crc8fc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crc8fc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   crc8fc_pkg::cfg_type   cfg_ff, cfg_in;
   crc8fc_pkg::entry_type push_entry;
   crc8fc_pkg::entry_type head;

   logic accept;
   logic queue_push;
   logic queue_pop;
   logic queue_full;
   logic queue_empty;

   // register file: writes to an index beyond the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            crc8fc_pkg::CSR_CRC_POLYNOMIAL:   cfg_in.crc_polynomial   = csr_write_data[7:0];
            crc8fc_pkg::CSR_RX_FRAME_LENGTH:  cfg_in.rx_frame_length  = csr_write_data[8:0];
            crc8fc_pkg::CSR_TX_FRAME_LENGTH:  cfg_in.tx_frame_length  = csr_write_data[8:0];
            crc8fc_pkg::CSR_SYNC_ENABLE:      cfg_in.sync_enable      = csr_write_data[0];
            crc8fc_pkg::CSR_SYNC_BYTE:        cfg_in.sync_byte        = csr_write_data[7:0];
            crc8fc_pkg::CSR_CRC_CHECK_ENABLE: cfg_in.crc_check_enable = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_polynomial   <= crc8fc_pkg::CRC_POLYNOMIAL_RESET;
         cfg_ff.rx_frame_length  <= crc8fc_pkg::RX_FRAME_LENGTH_RESET;
         cfg_ff.tx_frame_length  <= crc8fc_pkg::TX_FRAME_LENGTH_RESET;
         cfg_ff.sync_enable      <= crc8fc_pkg::SYNC_ENABLE_RESET;
         cfg_ff.sync_byte        <= crc8fc_pkg::SYNC_BYTE_RESET;
         cfg_ff.crc_check_enable <= crc8fc_pkg::CRC_CHECK_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // full only when the queue has no slot, so a waiting response blocks requests only once the queue fills
   assign req_full = queue_full;

   // front: frame counting, sync drop, crc update, one queue entry per result group
   crc8fc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_push      (req_push),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .accept        (accept),
      .queue_push    (queue_push),
      .queue_entry   (push_entry)
   );

   crc8fc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push && accept),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // back: output register, splits a frame-end tx entry into byte then crc
   crc8fc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .queue_empty     (queue_empty),
      .queue_pop       (queue_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_crc_byte (rsp_is_crc_byte),
      .rsp_crc_good    (rsp_crc_good),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== src/crc8fc_checker.sv =====
// ----------------------------------------------------------------------------
// crc8fc_checker
// port-level checks on the crc-8 frame block, bound to the top level
// ----------------------------------------------------------------------------
module crc8fc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_push,
   input logic                               req_full,
   input logic                               req_action,
   input logic [7:0]                         req_data_byte,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic                               rsp_kind,
   input logic [7:0]                         rsp_out_byte,
   input logic                               rsp_is_crc_byte,
   input logic                               rsp_crc_good,
   input logic                               rsp_last,
   input logic                               csr_write_enable,
   input logic [crc8fc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [crc8fc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // nothing to pop right after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response visible after reset");

   // a verdict is always the only result of its byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == crc8fc_pkg::KIND_VERDICT) |-> (rsp_last && !rsp_is_crc_byte))
      else $error("verdict not marked last or marked crc byte");

   // appended crc byte closes the group and carries no verdict
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_crc_byte) |-> (rsp_last && !rsp_crc_good &&
                                           rsp_kind == crc8fc_pkg::KIND_TX_BYTE))
      else $error("crc byte with wrong flags");

   // a frame-end tx byte is followed at once by its crc byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_kind == crc8fc_pkg::KIND_TX_BYTE && !rsp_last)
      |=> (!rsp_empty && rsp_is_crc_byte))
      else $error("crc byte does not follow last payload byte");

   // a stalled response stays visible and keeps its byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)))
      else $error("stalled response changed");

endmodule

bind crc8_frame_check_and_append crc8fc_checker u_crc8fc_checker (.*);
